### sv/sacl_pkg.sv
package sacl_pkg;

  localparam int MaxSets   = 64;
  localparam int MaxWays   = 8;
  localparam int AddrWidth = 32;
  localparam int SetW      = $clog2(MaxSets);
  localparam int WayW      = $clog2(MaxWays);
  localparam int LineW     = SetW + WayW;
  localparam int CntW      = $clog2(MaxWays + 1);

  localparam logic [2:0] CfgPolicy  = 3'd0;
  localparam logic [2:0] CfgWays    = 3'd1;
  localparam logic [2:0] CfgSetBits = 3'd2;
  localparam logic [2:0] CfgOffBits = 3'd3;
  localparam logic [2:0] CfgAddrBits = 3'd4;
  localparam logic [2:0] CfgHitCyc  = 3'd5;
  localparam logic [2:0] CfgMissPen = 3'd6;

  typedef enum logic [2:0] {
    StIdle,
    StRead,
    StScan,
    StWrite,
    StOut,
    StClear
  } state_e;

  typedef struct packed {
    logic [AddrWidth-1:0] address;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [2:0]  way_used;
    logic [31:0] cycle_total;
    logic [31:0] hit_total;
    logic [31:0] miss_total;
  } rsp_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [32:0] b);
    logic [33:0] s;
    s = {2'b0, a} + {1'b0, b};
    sat_add = (s > 34'hFFFF_FFFF) ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

### sv/sacl_stream_if.sv
interface sacl_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### sv/set_assoc_cache_lru_lfu_model_top.sv
// One address is taken per transfer and yields one result transfer. After reset the block
// runs a clearing pass over all 512 line valid bits and keeps in_if.ready low until it
// ends. With w the effective way count (ways_cfg_q, where 0 acts as 1 and values above 8 act
// as 8), one access then passes from one address transfer to the next through the accept
// step in idle, a read of the set's first line, a scan of the w ways through a shared tag and
// victim compare unit that walks the line memory, a write-back step and the loading of the
// output register. The block waits in the output state for as long as an earlier result has
// not been taken. Configuration writes are taken at any time but are meant only while the
// block is idle.
module set_assoc_cache_lru_lfu_model_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [15:0] cfg_data_i,
  sacl_stream_if.sink   in_if,
  sacl_stream_if.source out_if
);
  import sacl_pkg::*;

  logic        policy_q;
  logic [3:0]  ways_cfg_q;
  logic [2:0]  set_bits_q;
  logic [4:0]  off_bits_q;
  logic [5:0]  addr_bits_q;
  logic [15:0] hit_cyc_q;
  logic [15:0] miss_pen_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q    <= 1'b1;
      ways_cfg_q  <= 4'd1;
      set_bits_q  <= 3'd0;
      off_bits_q  <= 5'd0;
      addr_bits_q <= 6'd32;
      hit_cyc_q   <= 16'd1;
      miss_pen_q  <= 16'd0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgPolicy:   policy_q    <= cfg_data_i[0];
        CfgWays:     ways_cfg_q  <= cfg_data_i[3:0];
        CfgSetBits:  set_bits_q  <= cfg_data_i[2:0];
        CfgOffBits:  off_bits_q  <= cfg_data_i[4:0];
        CfgAddrBits: addr_bits_q <= cfg_data_i[5:0];
        CfgHitCyc:   hit_cyc_q   <= cfg_data_i;
        CfgMissPen:  miss_pen_q  <= cfg_data_i;
        default: ;
      endcase
    end
  end

  state_e state_q, state_d;

  logic [31:0]   tag_q;
  logic [SetW-1:0] set_q;
  logic [CntW-1:0] ways_q;
  logic [WayW-1:0] way_q;
  logic          found_q, empty_q;
  logic [WayW-1:0] hit_way_q, empty_way_q, best_way_q;
  logic [31:0]   best_q;
  logic [31:0]   hit_cnt_q;
  logic [31:0]   elapsed_q, hits_q, misses_q;
  rsp_t          rsp_q;
  logic          out_valid_q;
  logic [LineW-1:0] clr_q;

  logic [31:0]   tag_mem [MaxSets*MaxWays];
  logic [31:0]   cnt_mem [MaxSets*MaxWays];
  logic [31:0]   stamp_mem [MaxSets*MaxWays];
  logic          valid_mem [MaxSets*MaxWays];
  logic [31:0]   rd_tag_q, rd_cnt_q, rd_stamp_q;
  logic          rd_valid_q;

  logic [63:0] amask, addr_m, tag_full, set_full;
  logic [CntW-1:0] ways_eff;
  always_comb begin
    amask    = (addr_bits_q >= 6'd32) ? 64'hFFFF_FFFF : ((64'd1 << addr_bits_q) - 64'd1);
    addr_m   = {32'd0, in_if.data.address} & amask;
    tag_full = addr_m >> ({1'b0, off_bits_q} + {3'b0, set_bits_q});
    set_full = (addr_m >> off_bits_q) & ((64'd1 << set_bits_q) - 64'd1);
    if (ways_cfg_q == 4'd0) ways_eff = CntW'(1);
    else if (ways_cfg_q > 4'(MaxWays)) ways_eff = CntW'(MaxWays);
    else ways_eff = CntW'(ways_cfg_q);
  end

  logic [WayW-1:0] rd_way;
  logic [LineW-1:0] rd_addr, wr_addr;
  logic          last_way;
  logic [WayW-1:0] victim;
  logic          do_write;
  logic          do_clear;
  logic [31:0]   wr_tag, wr_cnt, wr_stamp;
  logic [31:0]   new_elapsed;
  logic          hit_now, miss_empty_now;
  logic [31:0]   key;

  assign last_way = ({1'b0, way_q} == CntW'(ways_q - CntW'(1)));
  assign rd_way   = (state_q == StScan) ? WayW'(way_q + WayW'(1)) : '0;
  assign rd_addr  = {set_q, rd_way};
  assign key      = policy_q ? rd_stamp_q : rd_cnt_q;
  assign hit_now  = rd_valid_q && (rd_tag_q == tag_q) && !found_q;
  assign miss_empty_now = !rd_valid_q && !empty_q;
  assign do_clear = (state_q == StClear);

  always_ff @(posedge clk_i) begin
    rd_tag_q   <= tag_mem[rd_addr];
    rd_cnt_q   <= cnt_mem[rd_addr];
    rd_stamp_q <= stamp_mem[rd_addr];
    rd_valid_q <= valid_mem[rd_addr];
    if (do_write) begin
      tag_mem[wr_addr]   <= wr_tag;
      cnt_mem[wr_addr]   <= wr_cnt;
      stamp_mem[wr_addr] <= wr_stamp;
    end
    if (do_clear) valid_mem[clr_q] <= 1'b0;
    else if (do_write) valid_mem[wr_addr] <= 1'b1;
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      StClear: if (clr_q == '1) state_d = StIdle;
      StIdle:  if (in_if.valid) state_d = StRead;
      StRead:  state_d = StScan;
      StScan:  if (last_way) state_d = StWrite;
      StWrite: state_d = StOut;
      StOut:   if (!out_valid_q || out_if.ready) state_d = StIdle;
      default: state_d = StIdle;
    endcase
  end

  always_comb begin
    victim = found_q ? hit_way_q : (empty_q ? empty_way_q : best_way_q);
    new_elapsed = found_q ? sat_add(elapsed_q, {17'd0, hit_cyc_q})
                          : sat_add(elapsed_q, {16'd0, miss_pen_q} + {17'd0, hit_cyc_q});
    do_write = (state_q == StWrite);
    wr_addr  = {set_q, victim};
    wr_tag   = tag_q;
    wr_cnt   = found_q ? sat_add(hit_cnt_q, 33'd1) : 32'd1;
    wr_stamp = found_q ? elapsed_q : new_elapsed;
  end

  assign in_if.ready = (state_q == StIdle);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StClear;
      clr_q       <= '0;
      elapsed_q   <= '0;
      hits_q      <= '0;
      misses_q    <= '0;
      out_valid_q <= 1'b0;
      found_q     <= 1'b0;
      empty_q     <= 1'b0;
      way_q       <= '0;
      hit_way_q   <= '0;
      empty_way_q <= '0;
      best_way_q  <= '0;
      best_q      <= '0;
      hit_cnt_q   <= '0;
      rsp_q       <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == StOut && (!out_valid_q || out_if.ready)) begin
        out_valid_q <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        StClear: clr_q <= LineW'(clr_q + 1'b1);
        StIdle: if (in_if.valid) begin
          found_q <= 1'b0;
          empty_q <= 1'b0;
          way_q   <= '0;
        end
        StScan: begin
          if (hit_now) begin
            found_q   <= 1'b1;
            hit_way_q <= way_q;
            hit_cnt_q <= rd_cnt_q;
          end
          if (miss_empty_now) begin
            empty_q     <= 1'b1;
            empty_way_q <= way_q;
          end
          if (way_q == '0 || key < best_q) begin
            best_q     <= key;
            best_way_q <= way_q;
          end
          way_q <= WayW'(way_q + WayW'(1));
        end
        StWrite: begin
          elapsed_q <= new_elapsed;
          if (found_q) hits_q <= sat_add(hits_q, 33'd1);
          else misses_q <= sat_add(misses_q, 33'd1);
        end
        StOut: if (!out_valid_q || out_if.ready) begin
          rsp_q.hit         <= found_q;
          rsp_q.way_used    <= 3'(victim);
          rsp_q.cycle_total <= elapsed_q;
          rsp_q.hit_total   <= hits_q;
          rsp_q.miss_total  <= misses_q;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == StIdle && in_if.valid) begin
      tag_q  <= tag_full[31:0];
      set_q  <= set_full[SetW-1:0];
      ways_q <= ways_eff;
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.data  = rsp_q;

`ifndef NO_ASSERTIONS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_if.ready |-> (state_q == StIdle)) else $error("ready outside idle");
  a_write_once: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWrite) |=> (state_q == StOut)) else $error("write not followed by output");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_if.valid && !out_if.ready) |=> (out_if.valid && $stable(out_if.data)))
    else $error("waiting result changed");
  a_counts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StWrite && found_q) |=> (hits_q != $past(hits_q) || hits_q == 32'hFFFF_FFFF))
    else $error("hit count not advanced");
`endif

endmodule
